@@ rtl/gcas_pkg.sv @@
// Shared types and constants for the grow chamber actuator scheduler.
`timescale 1ns / 1ps
`default_nettype none

package gcas_pkg;

    typedef enum logic [2:0] {
        CFG_SUNRISE     = 3'd0,
        CFG_SUNSET      = 3'd1,
        CFG_WATER_MIN   = 3'd2,
        CFG_WATER_TICKS = 3'd3,
        CFG_WIND_WAIT   = 3'd4,
        CFG_WIND_ON     = 3'd5,
        CFG_LOW_LIMIT   = 3'd6,
        CFG_HIGH_LIMIT  = 3'd7
    } cfg_idx_t;

    localparam int unsigned MIN_PER_HOUR = 60;

    typedef struct packed {
        logic        [10:0] sunrise_minute;
        logic        [10:0] sunset_minute;
        logic        [15:0] watering_ticks;
        logic        [15:0] wind_wait_ticks;
        logic        [15:0] wind_on_ticks;
        logic signed [7:0]  cold_limit;
        logic signed [7:0]  hot_limit;
        logic        [5:0]  water_hour;
        logic        [5:0]  water_min;
        logic        [5:0]  water_min_next;
    } cfg_t;

endpackage

`default_nettype wire

@@ rtl/gcas_cfg_regs.sv @@
// Configuration register file with the watering minute split into hour and minute.
`timescale 1ns / 1ps
`default_nettype none

module gcas_cfg_regs (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [2:0]    cfg_index,
    input  wire logic [15:0]   cfg_data,
    output gcas_pkg::cfg_t     cfg
);
    import gcas_pkg::*;

    cfg_t        cfg_reg;
    cfg_t        cfg_next;
    logic [21:0] wprod;
    logic [5:0]  wq0;
    logic [11:0] wrem0;
    logic [5:0]  whour;
    logic [5:0]  wmin;
    logic        cfg_fire;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign cfg       = cfg_reg;

    // divide by 60 through a reciprocal that never overshoots, then correct once
    always_comb
    begin
        wprod = {11'd0, cfg_data[10:0]} * 22'd1092;
        wq0   = wprod[21:16];
        wrem0 = {1'b0, cfg_data[10:0]} - 12'({6'd0, wq0} * 12'(MIN_PER_HOUR));
        if (wrem0 >= 12'(MIN_PER_HOUR))
        begin
            whour = wq0 + 6'd1;
            wmin  = 6'(wrem0 - 12'(MIN_PER_HOUR));
        end
        else
        begin
            whour = wq0;
            wmin  = 6'(wrem0);
        end
    end

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_fire)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_SUNRISE:     cfg_next.sunrise_minute  = cfg_data[10:0];
                CFG_SUNSET:      cfg_next.sunset_minute   = cfg_data[10:0];
                CFG_WATER_MIN:
                begin
                    cfg_next.water_hour     = whour;
                    cfg_next.water_min      = wmin;
                    cfg_next.water_min_next = (wmin == 6'(MIN_PER_HOUR - 1)) ? 6'd0
                                                                            : wmin + 6'd1;
                end
                CFG_WATER_TICKS: cfg_next.watering_ticks  = cfg_data;
                CFG_WIND_WAIT:   cfg_next.wind_wait_ticks = cfg_data;
                CFG_WIND_ON:     cfg_next.wind_on_ticks   = cfg_data;
                CFG_LOW_LIMIT:   cfg_next.cold_limit      = cfg_data[7:0];
                CFG_HIGH_LIMIT:  cfg_next.hot_limit       = cfg_data[7:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sunrise_minute  <= 11'd420;
            cfg_reg.sunset_minute   <= 11'd1260;
            cfg_reg.watering_ticks  <= 16'd60;
            cfg_reg.wind_wait_ticks <= 16'd600;
            cfg_reg.wind_on_ticks   <= 16'd60;
            cfg_reg.cold_limit      <= 8'sd15;
            cfg_reg.hot_limit       <= 8'sd30;
            cfg_reg.water_hour      <= 6'd8;
            cfg_reg.water_min       <= 6'd0;
            cfg_reg.water_min_next  <= 6'd1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/grow_chamber_actuator_scheduler_core.sv @@
// Top level: tick input register, actuator state update and result register.
// A tick word is held in the input register, its drive bits in the result registers.
// Throughput: one tick word per cycle unless out_stall holds; each tick's update is
// one pass of compares and 16-bit increments between the input and result registers.
// Reset: drives, flags and counters clear at once, configuration takes its defaults.
`timescale 1ns / 1ps
`default_nettype none

module grow_chamber_actuator_scheduler_core #(
    parameter int unsigned HEATER_ON_TICKS = 600
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [4:0]         hour_now,
    input  wire logic [5:0]         minute_now,
    input  wire logic signed [11:0] temperature,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic                    light_drive,
    output logic                    pump_drive,
    output logic                    fan_drive,
    output logic                    heater_drive,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [15:0]        cfg_data
);
    import gcas_pkg::*;

    cfg_t cfg;

    gcas_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    logic               s1_valid_reg;
    logic               s1_valid_next;
    logic [4:0]         hour_reg;
    logic [5:0]         minute_reg;
    logic signed [11:0] temp_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               in_fire;
    logic               adv;

    logic        light_reg, pump_reg, fan_reg, heater_reg, wind_reg, wdone_reg;
    logic        light_next, pump_next, fan_next, heater_next, wind_next, wdone_next;
    logic [15:0] wwait_cnt_reg, won_cnt_reg, pump_cnt_reg, heat_cnt_reg;
    logic [15:0] wwait_cnt_next, won_cnt_next, pump_cnt_next, heat_cnt_next;

    logic [10:0]        now_min;
    logic signed [11:0] low16;
    logic signed [11:0] high16;

    assign adv      = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !adv;
    assign in_fire  = in_valid && !in_stall;

    assign out_valid    = out_valid_reg;
    assign light_drive  = light_reg;
    assign pump_drive   = pump_reg;
    assign fan_drive    = fan_reg;
    assign heater_drive = heater_reg;

    always_comb
    begin
        s1_valid_next = in_fire ? 1'b1 : (adv ? 1'b0 : s1_valid_reg);
        if (adv)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign now_min = 11'({6'd0, hour_reg} * 11'(MIN_PER_HOUR)) + {5'd0, minute_reg};
    assign low16   = {cfg.cold_limit, 4'b0000};
    assign high16  = {cfg.hot_limit, 4'b0000};

    always_comb
    begin
        light_next     = light_reg;
        pump_next      = pump_reg;
        fan_next       = fan_reg;
        heater_next    = heater_reg;
        wind_next      = wind_reg;
        wdone_next     = wdone_reg;
        wwait_cnt_next = wwait_cnt_reg;
        won_cnt_next   = won_cnt_reg;
        pump_cnt_next  = pump_cnt_reg;
        heat_cnt_next  = heat_cnt_reg;

        if (adv)
        begin
            light_next = (cfg.sunrise_minute <= now_min) && (now_min <= cfg.sunset_minute);

            if (pump_next)
                pump_cnt_next = pump_cnt_next + 16'd1;
            if (!pump_next && ({1'b0, hour_reg} == cfg.water_hour) && !wdone_next
                && (minute_reg == cfg.water_min))
            begin
                pump_next     = 1'b1;
                wdone_next    = 1'b1;
                pump_cnt_next = 16'd0;
            end
            if (pump_next && (pump_cnt_next == cfg.watering_ticks))
            begin
                pump_next     = 1'b0;
                pump_cnt_next = 16'd0;
            end
            if (minute_reg == cfg.water_min_next)
                wdone_next = 1'b0;

            if (wind_next)
                won_cnt_next = won_cnt_next + 16'd1;
            if (wwait_cnt_next == cfg.wind_wait_ticks)
            begin
                fan_next       = 1'b1;
                wind_next      = 1'b1;
                wwait_cnt_next = 16'd0;
            end
            if (wind_next && (won_cnt_next == cfg.wind_on_ticks))
            begin
                fan_next     = 1'b0;
                wind_next    = 1'b0;
                won_cnt_next = 16'd0;
            end

            if (heater_next)
                heat_cnt_next = heat_cnt_next + 16'd1;
            if (temp_reg < low16)
                heater_next = 1'b1;
            if (heater_next && (heat_cnt_next == 16'(HEATER_ON_TICKS)))
            begin
                heater_next   = 1'b0;
                heat_cnt_next = 16'd0;
            end

            if (temp_reg > high16)
                fan_next = 1'b1;
            else if (!wind_next)
                fan_next = 1'b0;

            wwait_cnt_next = wwait_cnt_next + 16'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            hour_reg   <= hour_now;
            minute_reg <= minute_now;
            temp_reg   <= temperature;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            light_reg     <= 1'b0;
            pump_reg      <= 1'b0;
            fan_reg       <= 1'b0;
            heater_reg    <= 1'b0;
            wind_reg      <= 1'b0;
            wdone_reg     <= 1'b0;
            wwait_cnt_reg <= 16'd0;
            won_cnt_reg   <= 16'd0;
            pump_cnt_reg  <= 16'd0;
            heat_cnt_reg  <= 16'd0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            light_reg     <= light_next;
            pump_reg      <= pump_next;
            fan_reg       <= fan_next;
            heater_reg    <= heater_next;
            wind_reg      <= wind_next;
            wdone_reg     <= wdone_next;
            wwait_cnt_reg <= wwait_cnt_next;
            won_cnt_reg   <= won_cnt_next;
            pump_cnt_reg  <= pump_cnt_next;
            heat_cnt_reg  <= heat_cnt_next;
        end
    end

    a_pump_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !pump_reg |-> (pump_cnt_reg == 16'd0))
        else $error("pump count nonzero while pump off");

    a_heat_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !heater_reg |-> (heat_cnt_reg == 16'd0))
        else $error("heater count nonzero while heater off");

    a_wind_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !wind_reg |-> (won_cnt_reg == 16'd0))
        else $error("wind count nonzero while no burst");

    a_wind_fan: assert property (@(posedge clk) disable iff (!rst_n)
        wind_reg |-> fan_reg)
        else $error("wind burst active with fan off");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> ($stable(wwait_cnt_reg) && $stable(fan_reg)))
        else $error("state advanced while result stalled");

endmodule

`default_nettype wire

@@ bench/grow_chamber_actuator_scheduler_core_test.sv @@
// Self-checking bench for the grow chamber actuator scheduler core.
`timescale 1ns / 1ps

module grow_chamber_actuator_scheduler_core_test;

    import gcas_pkg::*;

    localparam int unsigned HEATER_TICKS = 600;
    localparam int unsigned LONG_HOLD    = 200;

    typedef struct packed {
        logic light;
        logic pump;
        logic fan;
        logic heater;
    } drives_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [4:0]         hour_now;
    logic [5:0]         minute_now;
    logic signed [11:0] temperature;
    logic               out_valid;
    logic               out_stall;
    logic               light_drive;
    logic               pump_drive;
    logic               fan_drive;
    logic               heater_drive;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [15:0]        cfg_data;

    // schedule settings as the block should hold them
    logic [10:0]        day_open;
    logic [10:0]        day_close;
    logic [10:0]        water_at;
    logic [15:0]        water_len;
    logic [15:0]        gust_wait;
    logic [15:0]        gust_len;
    logic signed [7:0]  cold_limit;
    logic signed [7:0]  hot_limit;

    // actuator state as the block should hold it
    bit                 lamp_on;
    bit                 pump_running;
    bit                 fan_running;
    bit                 heat_on;
    bit                 gust_active;
    bit                 watered;
    logic [15:0]        gust_wait_cnt;
    logic [15:0]        gust_on_cnt;
    logic [15:0]        pump_cnt;
    logic [15:0]        heat_cnt;

    drives_t            expected_drives[$];
    int unsigned        ticks_accepted;
    int unsigned        cfg_writes;
    int unsigned        mismatches;
    int unsigned        long_hold_asks;
    int unsigned        long_hold_seen;
    bit                 send_idle_on;
    bit                 rcv_idle_on;
    int                 day_minute;

    grow_chamber_actuator_scheduler_core #(
        .HEATER_ON_TICKS(HEATER_TICKS)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .hour_now     (hour_now),
        .minute_now   (minute_now),
        .temperature  (temperature),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .light_drive  (light_drive),
        .pump_drive   (pump_drive),
        .fan_drive    (fan_drive),
        .heater_drive (heater_drive),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int unsigned reachable(input logic [15:0] cnt, input bit running,
                                              input int unsigned span);
        if (running)
            return 16'(cnt + 1 + $urandom_range(0, span));
        return $urandom_range(0, span);
    endfunction

    function automatic logic signed [11:0] clip_temp(input int v);
        if (v > 2047)
            return 12'sd2047;
        if (v < -2048)
            return -12'sd2048;
        return v[11:0];
    endfunction

    task automatic advance_schedule(input logic [4:0] h, input logic [5:0] m,
                                    input logic signed [11:0] temp, output drives_t d);
        int unsigned now;
        int unsigned w_hour;
        int unsigned w_min;
        int t;
        int cold16;
        int hot16;
        now    = h * 60 + m;
        w_hour = water_at / 60;
        w_min  = water_at % 60;
        t      = temp;
        cold16 = int'(cold_limit) * 16;
        hot16  = int'(hot_limit) * 16;

        lamp_on = (now >= day_open) && (now <= day_close);

        if (pump_running)
            pump_cnt = pump_cnt + 16'd1;
        if (!pump_running && h == w_hour && !watered && m == w_min)
        begin
            pump_running = 1'b1;
            watered      = 1'b1;
            pump_cnt     = '0;
        end
        if (pump_running && pump_cnt == water_len)
        begin
            pump_running = 1'b0;
            pump_cnt     = '0;
        end
        if (m == (w_min + 1) % 60)
            watered = 1'b0;

        if (gust_active)
            gust_on_cnt = gust_on_cnt + 16'd1;
        if (gust_wait_cnt == gust_wait)
        begin
            fan_running   = 1'b1;
            gust_active   = 1'b1;
            gust_wait_cnt = '0;
        end
        if (gust_active && gust_on_cnt == gust_len)
        begin
            fan_running = 1'b0;
            gust_active = 1'b0;
            gust_on_cnt = '0;
        end

        if (heat_on)
            heat_cnt = heat_cnt + 16'd1;
        if (t < cold16)
            heat_on = 1'b1;
        if (heat_on && heat_cnt == 16'(HEATER_TICKS))
        begin
            heat_on  = 1'b0;
            heat_cnt = '0;
        end

        if (t > hot16)
            fan_running = 1'b1;
        else if (!gust_active)
            fan_running = 1'b0;

        gust_wait_cnt = gust_wait_cnt + 16'd1;

        d = '{lamp_on, pump_running, fan_running, heat_on};
    endtask

    always @(posedge clk)
    begin : accept_monitor
        drives_t d;
        if (!rst_n)
        begin
            day_open      = 11'd420;
            day_close     = 11'd1260;
            water_at      = 11'd480;
            water_len     = 16'd60;
            gust_wait     = 16'd600;
            gust_len      = 16'd60;
            cold_limit    = 8'sd15;
            hot_limit     = 8'sd30;
            lamp_on       = 1'b0;
            pump_running  = 1'b0;
            fan_running   = 1'b0;
            heat_on       = 1'b0;
            gust_active   = 1'b0;
            watered       = 1'b0;
            gust_wait_cnt = '0;
            gust_on_cnt   = '0;
            pump_cnt      = '0;
            heat_cnt      = '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_SUNRISE:     day_open   = cfg_data[10:0];
                    CFG_SUNSET:      day_close  = cfg_data[10:0];
                    CFG_WATER_MIN:   water_at   = cfg_data[10:0];
                    CFG_WATER_TICKS: water_len  = cfg_data;
                    CFG_WIND_WAIT:   gust_wait  = cfg_data;
                    CFG_WIND_ON:     gust_len   = cfg_data;
                    CFG_LOW_LIMIT:   cold_limit = cfg_data[7:0];
                    CFG_HIGH_LIMIT:  hot_limit  = cfg_data[7:0];
                    default:         ;
                endcase
                cfg_writes = cfg_writes + 1;
            end
            if (in_valid && !in_stall)
            begin
                advance_schedule(hour_now, minute_now, temperature, d);
                expected_drives.push_back(d);
                ticks_accepted = ticks_accepted + 1;
            end
        end
    end

    task automatic check_drive(input string name, input logic want, input logic got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0b actual %0b", $time, name, want, got);
            mismatches = mismatches + 1;
        end
    endtask

    always @(posedge clk)
    begin : drive_checker
        drives_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_drives.size() == 0)
            begin
                $display("%0t: drive word expected none actual %b", $time,
                         {light_drive, pump_drive, fan_drive, heater_drive});
                mismatches = mismatches + 1;
            end
            else
            begin
                want = expected_drives.pop_front();
                check_drive("light_drive", want.light, light_drive);
                check_drive("pump_drive", want.pump, pump_drive);
                check_drive("fan_drive", want.fan, fan_drive);
                check_drive("heater_drive", want.heater, heater_drive);
            end
        end
    end

    initial
    begin : receiver
        int unsigned hold_left;
        int unsigned burst_left;
        int unsigned n;
        hold_left  = 0;
        burst_left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left != 0)
            begin
                hold_left = hold_left - 1;
                out_stall <= 1'b1;
            end
            else if (long_hold_seen != long_hold_asks)
            begin
                long_hold_seen = long_hold_asks;
                hold_left      = LONG_HOLD - 1;
                out_stall <= 1'b1;
            end
            else if (!rcv_idle_on)
                out_stall <= 1'b0;
            else if (burst_left != 0)
            begin
                burst_left = burst_left - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                n = gap_len();
                if (n == 0)
                    out_stall <= 1'b0;
                else
                begin
                    burst_left = n - 1;
                    out_stall <= 1'b1;
                end
            end
        end
    end

    task automatic send_tick(input logic [4:0] h, input logic [5:0] m,
                             input logic signed [11:0] t);
        int unsigned seen;
        int unsigned gap;
        gap = send_idle_on ? gap_len() : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        seen = ticks_accepted;
        in_valid    <= 1'b1;
        hour_now    <= h;
        minute_now  <= m;
        temperature <= t;
        do
            @(negedge clk);
        while (ticks_accepted == seen);
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        while (expected_drives.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [15:0] value);
        int unsigned seen;
        seen = cfg_writes;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(negedge clk);
        while (cfg_writes == seen);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_schedule(input int open_at, input int close_at, input int water_min,
                                input int water_ticks, input int gust_wait_ticks,
                                input int gust_on_ticks, input int cold, input int hot);
        wait_drain();
        write_reg(CFG_SUNRISE, 16'(open_at));
        write_reg(CFG_SUNSET, 16'(close_at));
        write_reg(CFG_WATER_MIN, 16'(water_min));
        write_reg(CFG_WATER_TICKS, 16'(water_ticks));
        write_reg(CFG_WIND_WAIT, 16'(gust_wait_ticks));
        write_reg(CFG_WIND_ON, 16'(gust_on_ticks));
        write_reg(CFG_LOW_LIMIT, 16'(cold));
        write_reg(CFG_HIGH_LIMIT, 16'(hot));
    endtask

    // counters must still be able to reach their new targets
    task automatic pick_schedule();
        int open_at;
        int cold;
        wait_drain();
        open_at = $urandom_range(0, 1439);
        cold    = $urandom_range(0, 40);
        cold    = cold - 10;
        set_schedule(open_at, $urandom_range(open_at, 1439), $urandom_range(0, 1439),
                     reachable(pump_cnt, pump_running, 25),
                     reachable(gust_wait_cnt, 1'b1, 50),
                     reachable(gust_on_cnt, gust_active, 20),
                     cold, cold + $urandom_range(0, 20));
    endtask

    task automatic send_random_tick();
        int unsigned r;
        int key;
        int v;
        int offs;
        logic [4:0] h;
        logic [5:0] m;
        r = $urandom_range(0, 99);
        if (r >= 55 && r < 82)
            day_minute = (day_minute + 1) % 1440;
        else if (r >= 82 && r < 92)
        begin
            case ($urandom_range(0, 2))
                0:       key = day_open;
                1:       key = day_close;
                default: key = water_at;
            endcase
            offs       = $urandom_range(0, 3);
            day_minute = (key % 1440 + 1440 - offs) % 1440;
        end
        if (r >= 95)
        begin
            h = 5'($urandom_range(0, 31));
            m = 6'($urandom_range(0, 63));
        end
        else
        begin
            h = 5'(day_minute / 60);
            m = 6'(day_minute % 60);
        end
        r    = $urandom_range(0, 99);
        offs = $urandom_range(0, 48);
        if (r < 35)
            v = int'(cold_limit) * 16 + offs - 24;
        else if (r < 65)
            v = int'(hot_limit) * 16 + offs - 24;
        else
            v = int'($signed(12'($urandom)));
        send_tick(h, m, clip_temp(v));
    endtask

    task automatic test_reset_settings();
        send_tick(5'd0, 6'd0, 12'sd240);
        send_tick(5'd0, 6'd1, 12'sd239);
        send_tick(5'd6, 6'd59, -12'sd2048);
        send_tick(5'd7, 6'd0, 12'sd0);
        send_tick(5'd21, 6'd0, 12'sd480);
        send_tick(5'd21, 6'd1, 12'sd481);
        send_tick(5'd23, 6'd59, 12'sd2047);
        send_tick(5'd31, 6'd63, 12'sd0);
    endtask

    task automatic test_register_extremes();
        set_schedule(0, 2047, 1500, 0, 0, 0, -128, 127);
        send_tick(5'd0, 6'd0, -12'sd2048);
        send_tick(5'd25, 6'd0, 12'sd2047);
        send_tick(5'd31, 6'd63, 12'sd0);
    endtask

    task automatic test_inverted_window();
        wait_drain();
        set_schedule(1439, 0, 1439, 3, reachable(gust_wait_cnt, 1'b1, 2), 0, 127, -128);
        send_tick(5'd23, 6'd59, 12'sd0);
        send_tick(5'd23, 6'd59, 12'sd0);
        send_tick(5'd0, 6'd0, -12'sd2048);
        send_tick(5'd0, 6'd0, -12'sd2048);
        send_tick(5'd23, 6'd59, -12'sd2048);
    endtask

    task automatic test_output_hold();
        pick_schedule();
        send_idle_on   = 1'b0;
        long_hold_asks = long_hold_asks + 1;
        repeat (40) send_random_tick();
        wait_drain();
        send_idle_on = 1'b1;
    endtask

    task automatic test_random_phases();
        for (int p = 0; p < 6; p++)
        begin
            case (p)
                2:       set_schedule(0, 1439, 1439, 65535, 65535, 65535, 127, -128);
                4:       set_schedule($urandom, $urandom, $urandom, $urandom,
                                      $urandom, $urandom, $urandom, $urandom);
                default: pick_schedule();
            endcase
            send_idle_on = (p != 1);
            rcv_idle_on  = (p != 1);
            repeat (75) send_random_tick();
        end
    endtask

    initial
    begin
        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        hour_now       <= '0;
        minute_now     <= '0;
        temperature    <= '0;
        cfg_valid      <= 1'b0;
        cfg_index      <= '0;
        cfg_data       <= '0;
        ticks_accepted  = 0;
        cfg_writes      = 0;
        mismatches      = 0;
        long_hold_asks  = 0;
        long_hold_seen  = 0;
        send_idle_on    = 1'b1;
        rcv_idle_on     = 1'b1;
        day_minute      = 400;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_settings();
        test_register_extremes();
        test_inverted_window();
        test_output_hold();
        test_random_phases();
        wait_drain();

        $display("Run covered %0d ticks and %0d register writes across several schedules,",
                 ticks_accepted, cfg_writes);
        $display("with random stalls on both sides and one long output hold.");
        if (mismatches == 0 && expected_drives.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
